// ===== src/rbmc_pkg.sv =====
// Shared types and constants for the maze carver.
// No dependencies; imported by the top, the mod-100 unit and the testbench.
`timescale 1ns / 1ps
package rbmc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int RV_BITS        = 31;
  localparam int REM_BITS       = 7;
  localparam logic [7:0] MOD_BASE = 8'd100;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CARVE = 2'd1,
    PH_ERASE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PERCENT = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  // cell word: bit0 open, bits1-4 untried dirs, bit5 linked, bits6-7 parent dir
  localparam logic [7:0] C_WALL  = 8'h00;
  localparam logic [7:0] C_OPEN  = 8'h01;
  localparam logic [7:0] C_ROOM  = 8'h1F;
  localparam logic [7:0] C_START = 8'h3F;
  localparam logic [7:0] C_LINK  = 8'h20;

  localparam logic [5:0] RST_WIDTH   = 6'd31;
  localparam logic [5:0] RST_HEIGHT  = 6'd31;
  localparam logic [6:0] RST_PERCENT = 7'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [30:0] random_value;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
  } in_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       cell_open;
    logic       draw_used;
  } out_t;

endpackage

// ===== src/random_backtracker_maze_carver_top.sv =====
// Maze carver top: request FSM around the cell RAM and the mod-100 unit.
// Depends on rbmc_pkg, rbmc_ram, rbmc_mod100.
// Start writes one RAM word per cell of the grid in use. A draw while carving reads
// and updates the current room and its neighbour, then walks back over exhausted rooms
// and, when carving ends, scans for the first wall; a draw while erasing waits on the
// mod-100 unit, then scans to the next wall. One request in flight; a finished beat
// waits in the output register. Sync reset clears control; RAM holds garbage until start.
`timescale 1ns / 1ps
module random_backtracker_maze_carver_top #(
  parameter int MAX_WIDTH  = rbmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rbmc_pkg::DEF_MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rbmc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rbmc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [6:0]     cfg_data
);
  import rbmc_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_INIT  = 13'h0002,
    S_CCHK  = 13'h0004,
    S_NRD   = 13'h0008,
    S_NCHK  = 13'h0010,
    S_WWR   = 13'h0020,
    S_BRD   = 13'h0040,
    S_BCHK  = 13'h0080,
    S_SRD   = 13'h0100,
    S_SCHK  = 13'h0200,
    S_EMOD  = 13'h0400,
    S_RWAIT = 13'h0800,
    S_RESP  = 13'h1000
  } state_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [5:0]      gw_r, gh_r;
  logic [6:0]      ep_r;
  logic [XW-1:0]   cur_w_r, cur_w_nxt;
  logic [YW-1:0]   cur_h_r, cur_h_nxt;
  logic [XW-1:0]   cx_r, cx_nxt, nx_r, nx_nxt, ex_r, ex_nxt;
  logic [YW-1:0]   cy_r, cy_nxt, ny_r, ny_nxt, ey_r, ey_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic            open_r, open_nxt, used_r, used_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata, mem_rdata;
  logic            mod_start, mod_done;
  logic [6:0]      mod_rem;

  logic [XW:0]     sx;
  logic [YW:0]     sy;
  logic [XW-1:0]   wx;
  logic [YW-1:0]   wy;
  logic [7:0]      c;

  function automatic logic [8:0] fit_dim(logic [5:0] v, logic [8:0] maxv);
    logic [8:0] t;
    t = {3'd0, v};
    if (t < 9'd3) t = 9'd3;
    if (t > maxv) t = maxv;
    if (!t[0]) t = t - 9'd1;
    return t;
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [XW-1:0] x, logic [YW-1:0] y);
    logic [AW+1:0] a;
    a = (AW+2)'(y) * (AW+2)'(MAX_WIDTH) + (AW+2)'(x);
    return a[AW-1:0];
  endfunction

  rbmc_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rbmc_mod100 u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_data.random_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= RST_WIDTH;
      gh_r <= RST_HEIGHT;
      ep_r <= RST_PERCENT;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:   gw_r <= cfg_data[5:0];
        CFG_HEIGHT:  gh_r <= cfg_data[5:0];
        CFG_PERCENT: ep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cur_w_nxt     = cur_w_r;
    cur_h_nxt     = cur_h_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    dir_nxt       = dir_r;
    open_nxt      = open_r;
    used_nxt      = used_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = addr_of(cx_r, cy_r);
    mem_wdata     = C_WALL;
    mod_start     = 1'b0;
    c             = mem_rdata;
    sx            = {1'b0, cx_r};
    sy            = {1'b0, cy_r};
    wx            = cx_r;
    wy            = cy_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          open_nxt = 1'b0;
          used_nxt = 1'b0;
          state_nxt = S_RESP;
          unique case (req_t'(in_data.req_type))
            REQ_START: begin
              cur_w_nxt = XW'(fit_dim(gw_r, 9'(MAX_WIDTH)));
              cur_h_nxt = YW'(fit_dim(gh_r, 9'(MAX_HEIGHT)));
              ex_nxt    = '0;
              ey_nxt    = '0;
              phase_nxt = PH_CARVE;
              state_nxt = S_INIT;
            end
            REQ_DRAW: begin
              if (phase_r == PH_CARVE) begin
                used_nxt  = 1'b1;
                dir_nxt   = in_data.random_value[1:0];
                mem_re    = 1'b1;
                state_nxt = S_CCHK;
              end else if (phase_r == PH_ERASE) begin
                used_nxt  = 1'b1;
                mod_start = 1'b1;
                state_nxt = S_EMOD;
              end
            end
            REQ_READ: begin
              if ((9'(in_data.cell_x) < 9'(cur_w_r)) &&
                  (9'(in_data.cell_y) < 9'(cur_h_r))) begin
                mem_re    = 1'b1;
                mem_addr  = addr_of(XW'(in_data.cell_x), YW'(in_data.cell_y));
                state_nxt = S_RWAIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_INIT: begin
        mem_we   = 1'b1;
        mem_addr = addr_of(ex_r, ey_r);
        if (ex_r[0] && ey_r[0]) begin
          mem_wdata = (ex_r == XW'(1) && ey_r == YW'(1)) ? C_START : C_ROOM;
        end
        if (ey_r == cur_h_r - YW'(1)) begin
          ey_nxt = '0;
          ex_nxt = ex_r + XW'(1);
        end else begin
          ey_nxt = ey_r + YW'(1);
        end
        if (ex_r == cur_w_r - XW'(1) && ey_r == cur_h_r - YW'(1)) begin
          cx_nxt    = XW'(1);
          cy_nxt    = YW'(1);
          ex_nxt    = '0;
          ey_nxt    = '0;
          state_nxt = S_RESP;
        end
      end

      S_CCHK: begin
        state_nxt = S_BRD;
        case (dir_r)
          2'd0:    sx = {1'b0, cx_r} + (XW+1)'(2);
          2'd1:    sy = {1'b0, cy_r} + (YW+1)'(2);
          2'd2:    sx = {1'b0, cx_r} - (XW+1)'(2);
          default: sy = {1'b0, cy_r} - (YW+1)'(2);
        endcase
        if (c[{1'b0, dir_r} + 3'd1]) begin
          mem_we    = 1'b1;
          mem_wdata = c & ~(8'd1 << ({1'b0, dir_r} + 3'd1));
          if (sx < {1'b0, cur_w_r} && sy < {1'b0, cur_h_r}) begin
            nx_nxt    = sx[XW-1:0];
            ny_nxt    = sy[YW-1:0];
            state_nxt = S_NRD;
          end
        end
      end

      S_NRD: begin
        mem_re    = 1'b1;
        mem_addr  = addr_of(nx_r, ny_r);
        state_nxt = S_NCHK;
      end

      S_NCHK: begin
        state_nxt = S_BRD;
        if (c[0] && !c[5]) begin
          mem_we    = 1'b1;
          mem_addr  = addr_of(nx_r, ny_r);
          mem_wdata = c | C_LINK | {dir_r ^ 2'd2, 6'd0};
          state_nxt = S_WWR;
        end
      end

      S_WWR: begin
        case (dir_r)
          2'd0:    wx = cx_r + XW'(1);
          2'd1:    wy = cy_r + YW'(1);
          2'd2:    wx = cx_r - XW'(1);
          default: wy = cy_r - YW'(1);
        endcase
        mem_we    = 1'b1;
        mem_addr  = addr_of(wx, wy);
        mem_wdata = C_OPEN;
        cx_nxt    = nx_r;
        cy_nxt    = ny_r;
        state_nxt = S_BRD;
      end

      S_BRD: begin
        mem_re    = 1'b1;
        state_nxt = S_BCHK;
      end

      S_BCHK: begin
        case (c[7:6])
          2'd0:    sx = {1'b0, cx_r} + (XW+1)'(2);
          2'd1:    sy = {1'b0, cy_r} + (YW+1)'(2);
          2'd2:    sx = {1'b0, cx_r} - (XW+1)'(2);
          default: sy = {1'b0, cy_r} - (YW+1)'(2);
        endcase
        if (c[4:1] != 4'd0) begin
          state_nxt = S_RESP;
        end else if ((cx_r == XW'(1) && cy_r == YW'(1)) ||
                     !(sx < {1'b0, cur_w_r} && sy < {1'b0, cur_h_r}) ||
                     (sx == (XW+1)'(1) && sy == (YW+1)'(1))) begin
          // carving over: park on (1,1) if reached, then scan for walls
          if (sx < {1'b0, cur_w_r} && sy < {1'b0, cur_h_r} &&
              !(cx_r == XW'(1) && cy_r == YW'(1))) begin
            cx_nxt = sx[XW-1:0];
            cy_nxt = sy[YW-1:0];
          end
          ex_nxt    = '0;
          ey_nxt    = '0;
          state_nxt = S_SRD;
        end else begin
          cx_nxt    = sx[XW-1:0];
          cy_nxt    = sy[YW-1:0];
          state_nxt = S_BRD;
        end
      end

      S_SRD: begin
        if (ex_r < cur_w_r) begin
          mem_re    = 1'b1;
          mem_addr  = addr_of(ex_r, ey_r);
          state_nxt = S_SCHK;
        end else begin
          phase_nxt = PH_DONE;
          state_nxt = S_RESP;
        end
      end

      S_SCHK: begin
        if (!c[0]) begin
          phase_nxt = PH_ERASE;
          state_nxt = S_RESP;
        end else begin
          if (ey_r == cur_h_r - YW'(1)) begin
            ey_nxt = '0;
            ex_nxt = ex_r + XW'(1);
          end else begin
            ey_nxt = ey_r + YW'(1);
          end
          state_nxt = S_SRD;
        end
      end

      S_EMOD: begin
        if (mod_done) begin
          mem_addr = addr_of(ex_r, ey_r);
          mem_wdata = C_OPEN;
          mem_we   = (({1'b0, mod_rem} + 8'd1) < {1'b0, ep_r});
          if (ey_r == cur_h_r - YW'(1)) begin
            ey_nxt = '0;
            ex_nxt = ex_r + XW'(1);
          end else begin
            ey_nxt = ey_r + YW'(1);
          end
          state_nxt = S_SRD;
        end
      end

      S_RWAIT: begin
        open_nxt  = c[0];
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.phase     = phase_r;
          out_nxt.cell_open = open_r;
          out_nxt.draw_used = used_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      cur_w_r     <= XW'(3);
      cur_h_r     <= YW'(3);
      cx_r        <= XW'(1);
      cy_r        <= YW'(1);
      ex_r        <= '0;
      ey_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      cur_w_r     <= cur_w_nxt;
      cur_h_r     <= cur_h_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      ex_r        <= ex_nxt;
      ey_r        <= ey_nxt;
    end
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    dir_r  <= dir_nxt;
    open_r <= open_nxt;
    used_r <= used_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== src/rbmc_ram.sv =====
// Cell store: single-port synchronous RAM with a registered read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rbmc_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rbmc_mod100.sv =====
// Remainder of a 31-bit value by 100 through a reciprocal multiply.
// Uses rbmc_pkg.
`timescale 1ns / 1ps
module rbmc_mod100 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [30:0]            value,
  output logic                   done,
  output logic [6:0]             rem
);
  import rbmc_pkg::*;

  // floor(v / 100) == (v * RECIP) >> 37 for every v below 2^32
  localparam logic [31:0] RECIP   = 32'h51EB851F;
  localparam int          Q_SHIFT = 37;

  logic [RV_BITS-1:0]  val_r, val_nxt;
  logic [RV_BITS+31:0] prod_r, prod_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic                ld_r, mul_r, done_r;
  logic [31:0]         quo, diff;

  always_comb begin
    val_nxt  = start ? value : val_r;
    prod_nxt = (RV_BITS+32)'(val_r) * (RV_BITS+32)'(RECIP);
    quo      = 32'(prod_r[RV_BITS+31:Q_SHIFT]);
    diff     = {1'b0, val_r} - quo * 32'(MOD_BASE);
    rem_nxt  = diff[REM_BITS-1:0];
  end

  // load, multiply, subtract: start passes through ld_r, mul_r and done_r; done pulses with rem
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ld_r   <= start;
      mul_r  <= ld_r;
      done_r <= mul_r;
    end
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== test/random_backtracker_maze_carver_top_tb.sv =====
// Testbench for the maze carver: directed table, then random mazes of mixed sizes.
// Depends on rbmc_pkg and random_backtracker_maze_carver_top; self-checking via predictor.
`timescale 1ns / 1ps
module random_backtracker_maze_carver_top_tb;
  import rbmc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_NONE;
  logic [6:0] cfg_data = '0;

  random_backtracker_maze_carver_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15ms;
    $display("Some tests failed");
    $finish;
  end

  // ---------------- maze predictor ----------------
  logic [7:0] maze_ram [0:4095];
  int         pos_x, pos_y, wall_idx;
  int         live_w = 3, live_h = 3;
  phase_t     mz_phase = PH_IDLE;
  int         cfg_w = int'(RST_WIDTH), cfg_h = int'(RST_HEIGHT), cfg_pct = int'(RST_PERCENT);

  out_t exp_q[$];
  int   err_count = 0;
  int   accepted = 0;

  function automatic int step_x(int d);
    return (d == 0) ? 2 : (d == 2) ? -2 : 0;
  endfunction

  function automatic int step_y(int d);
    return (d == 1) ? 2 : (d == 3) ? -2 : 0;
  endfunction

  function automatic int fit_size(int v);
    if (v < 3) v = 3;
    if (v > 64) v = 64;
    if (v % 2 == 0) v = v - 1;
    return v;
  endfunction

  function void find_wall(int idx);
    int total;
    total = live_w * live_h;
    while (idx < total) begin
      if (!maze_ram[(idx % live_h) * 64 + idx / live_h][0]) begin
        wall_idx = idx;
        mz_phase = PH_ERASE;
        return;
      end
      idx++;
    end
    wall_idx = total;
    mz_phase = PH_DONE;
  endfunction

  function void build_maze();
    live_w = fit_size(cfg_w);
    live_h = fit_size(cfg_h);
    for (int i = 0; i < 4096; i++) maze_ram[i] = C_WALL;
    for (int y = 0; y < live_h; y++)
      for (int x = 0; x < live_w; x++)
        if (x % 2 == 1 && y % 2 == 1) maze_ram[y * 64 + x] = C_ROOM;
    maze_ram[65] = maze_ram[65] | C_LINK;
    pos_x = 1;
    pos_y = 1;
    wall_idx = 0;
    mz_phase = PH_CARVE;
  endfunction

  function void carve_step(logic [30:0] r);
    int d, ci, nx, ny, di, pd, px, py;
    d = int'(r[1:0]);
    ci = pos_y * 64 + pos_x;
    if (maze_ram[ci][d+1]) begin
      maze_ram[ci][d+1] = 1'b0;
      nx = pos_x + step_x(d);
      ny = pos_y + step_y(d);
      if (nx >= 0 && ny >= 0 && nx < live_w && ny < live_h) begin
        di = ny * 64 + nx;
        if (maze_ram[di][0] && !maze_ram[di][5]) begin
          maze_ram[((pos_y + ny) / 2) * 64 + (pos_x + nx) / 2][0] = 1'b1;
          maze_ram[di][5] = 1'b1;
          maze_ram[di][7:6] = 2'(d ^ 2);
          pos_x = nx;
          pos_y = ny;
        end
      end
    end
    // walk back over exhausted rooms; draws are not consumed here
    for (int g = 0; g <= live_w * live_h; g++) begin
      if (maze_ram[pos_y * 64 + pos_x][4:1] != 4'b0) return;
      if (pos_x == 1 && pos_y == 1) break;
      pd = int'(maze_ram[pos_y * 64 + pos_x][7:6]);
      px = pos_x + step_x(pd);
      py = pos_y + step_y(pd);
      if (px < 0 || py < 0 || px >= live_w || py >= live_h) break;
      pos_x = px;
      pos_y = py;
      if (pos_x == 1 && pos_y == 1) break;
    end
    find_wall(0);
  endfunction

  function automatic out_t predict_beat(in_t it);
    out_t o;
    o = '0;
    case (it.req_type)
      REQ_START: build_maze();
      REQ_DRAW: begin
        if (mz_phase == PH_CARVE) begin
          o.draw_used = 1'b1;
          carve_step(it.random_value);
        end else if (mz_phase == PH_ERASE) begin
          o.draw_used = 1'b1;
          if (it.random_value % 100 + 1 < cfg_pct)
            maze_ram[(wall_idx % live_h) * 64 + wall_idx / live_h][0] = 1'b1;
          find_wall(wall_idx + 1);
        end
      end
      REQ_READ: begin
        if (it.cell_x < live_w && it.cell_y < live_h)
          o.cell_open = maze_ram[it.cell_y * 64 + it.cell_x][0];
      end
      default: ;
    endcase
    o.phase = mz_phase;
    return o;
  endfunction

  // ---------------- sender ----------------
  int burst_left = 0;

  task automatic send_req(in_t it, bit typed, out_t typed_exp);
    int gap;
    out_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    p = predict_beat(it);
    exp_q.insert(exp_q.size(), typed ? typed_exp : p);
    accepted++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:   cfg_w = int'(val[5:0]);
      CFG_HEIGHT:  cfg_h = int'(val[5:0]);
      CFG_PERCENT: cfg_pct = int'(val);
      default: ;
    endcase
  endtask

  function automatic in_t mk_req(req_t rq, logic [30:0] rv, logic [5:0] x, logic [5:0] y);
    in_t it;
    it.req_type = rq;
    it.random_value = rv;
    it.cell_x = x;
    it.cell_y = y;
    return it;
  endfunction

  function automatic out_t mk_beat(phase_t ph, logic op, logic used);
    out_t o;
    o.phase = ph;
    o.cell_open = op;
    o.draw_used = used;
    return o;
  endfunction

  typedef struct {
    in_t  it;
    bit   typed;
    out_t exp;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic int pick_size(int big_left);
    int s;
    s = $urandom_range(0, 19);
    if (s < 2) return (big_left > 0) ? 63 : 0;
    if (s < 5) return $urandom_range(0, 2);
    if (s < 16) return $urandom_range(3, 11);
    return $urandom_range(12, 25);
  endfunction

  function automatic logic [6:0] pick_percent();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd100;
      3: return 7'd101;
      4: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic in_t rand_read();
    if ($urandom_range(0, 3) != 0)
      return mk_req(REQ_READ, 31'($urandom), 6'($urandom_range(0, live_w - 1)),
                    6'($urandom_range(0, live_h - 1)));
    return mk_req(REQ_READ, 31'($urandom), 6'($urandom), 6'($urandom));
  endfunction

  initial begin
    int draws, big_left;
    in_t it;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset configuration (31 x 31)
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_NOP, 31'h7FFFFFFF, 6'h3F, 6'h3F), 1'b1,
                                     mk_beat(PH_IDLE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'd5, 6'd0, 6'd0), 1'b1,
                                     mk_beat(PH_IDLE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_START, 31'd0, 6'd0, 6'd0), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd1, 6'd1), 1'b1,
                                     mk_beat(PH_CARVE, 1'b1, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd0, 6'd0), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd63, 6'd63), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd30, 6'd30), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b0)});
    // up and left from (1,1) leave the grid
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'h7FFFFFFF, 6'd0, 6'd0), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b1)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'd2, 6'd0, 6'd0), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b1)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'd0, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd2, 6'd1), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'h55555555, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'h2AAAAAAA, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'd3, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_DRAW, 31'd1, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd29, 6'd29), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_NOP, 31'd0, 6'd0, 6'd0), 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_START, 31'h7FFFFFFF, 6'h3F, 6'h3F), 1'b1,
                                     mk_beat(PH_CARVE, 1'b0, 1'b0)});
    dir_tab.insert(dir_tab.size(), '{mk_req(REQ_READ, 31'd0, 6'd3, 6'd1), 1'b1,
                                     mk_beat(PH_CARVE, 1'b1, 1'b0)});
    foreach (dir_tab[i]) send_req(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].exp);

    // random mazes; a few at full size, capped in draws
    big_left = 3;
    while (accepted < 945) begin
      drain();
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_WIDTH, 7'(pick_size(big_left)));
        write_reg(CFG_HEIGHT, 7'(pick_size(big_left)));
        if (cfg_w == 63 || cfg_h == 63) big_left--;
      end
      if ($urandom_range(0, 1) != 0) write_reg(CFG_PERCENT, pick_percent());
      send_req(mk_req(REQ_START, 31'($urandom), 6'($urandom), 6'($urandom)), 0, '0);
      draws = 0;
      while ((mz_phase == PH_CARVE || mz_phase == PH_ERASE) && draws < 250 &&
             accepted < 945) begin
        case ($urandom_range(0, 99)) inside
          [0:86]: begin
            it = mk_req(REQ_DRAW, 31'($urandom), 6'($urandom), 6'($urandom));
            draws++;
          end
          [87:95]: it = rand_read();
          [96:98]: it = mk_req(REQ_NOP, 31'($urandom), 6'($urandom), 6'($urandom));
          default: it = mk_req(REQ_START, 31'($urandom), 6'($urandom), 6'($urandom));
        endcase
        if ($urandom_range(0, 49) == 0) drain();
        send_req(it, 0, '0);
      end
      repeat ($urandom_range(1, 4)) begin
        it = ($urandom_range(0, 1) != 0) ? rand_read()
             : mk_req(REQ_DRAW, 31'($urandom), 6'($urandom), 6'($urandom));
        send_req(it, 0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------- receiver and checker ----------------
  int stall_mode = 0;
  int stall_cnt = 0;

  always @(posedge clk) begin
    out_t e;
    if (out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        err_count++;
      end else begin
        e = exp_q.pop_front();
        if (out_data.phase !== e.phase) begin
          $error("phase: expected %0d, got %0d", e.phase, out_data.phase);
          err_count++;
        end
        if (out_data.cell_open !== e.cell_open) begin
          $error("cell_open: expected %0d, got %0d", e.cell_open, out_data.cell_open);
          err_count++;
        end
        if (out_data.draw_used !== e.draw_used) begin
          $error("draw_used: expected %0d, got %0d", e.draw_used, out_data.draw_used);
          err_count++;
        end
      end
    end
    stall_cnt++;
    if (stall_cnt % 200 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 1) != 0);
      2: out_stall <= (stall_cnt % 4 == 0);
      3: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= 1'b0;
    endcase
  end

endmodule
